// ===== rtl/twg_pkg.sv =====
// Shared types, constants and the quarter-wave sine function of the waveform generator.
`default_nettype none
package twg_pkg;

    localparam int TIME_W = 32;
    localparam int PER_W  = 24;
    localparam int VAL_W  = 32;
    localparam int CODE_W = 3;
    localparam int ADDR_W = 3;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int AMP_FRAC_BITS_DEF   = 16;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    localparam logic [ADDR_W-1:0] REG_PERIOD     = 3'd0;
    localparam logic [ADDR_W-1:0] REG_WAVEFORM   = 3'd1;
    localparam logic [ADDR_W-1:0] REG_VALUE_KIND = 3'd2;
    localparam logic [ADDR_W-1:0] REG_LOW        = 3'd3;
    localparam logic [ADDR_W-1:0] REG_HIGH       = 3'd4;
    localparam logic [ADDR_W-1:0] REG_ALERT_PER  = 3'd5;
    localparam logic [ADDR_W-1:0] REG_ALERT_DUR  = 3'd6;

    localparam logic [CODE_W-1:0] WAVE_SAW     = 3'd0;
    localparam logic [CODE_W-1:0] WAVE_INV_SAW = 3'd1;
    localparam logic [CODE_W-1:0] WAVE_SINE    = 3'd2;
    localparam logic [CODE_W-1:0] WAVE_SQUARE  = 3'd3;
    localparam logic [CODE_W-1:0] WAVE_TRI     = 3'd4;

    localparam logic [CODE_W-1:0] KIND_BOOL  = 3'd0;
    localparam logic [CODE_W-1:0] KIND_RANGE = 3'd1;
    localparam logic [CODE_W-1:0] KIND_INT   = 3'd2;
    localparam logic [CODE_W-1:0] KIND_RINT  = 3'd3;

    typedef struct packed {
        logic [PER_W-1:0]  period;
        logic [CODE_W-1:0] waveform;
        logic [CODE_W-1:0] kind;
        logic [VAL_W-1:0]  low;
        logic [VAL_W-1:0]  high;
        logic [PER_W-1:0]  aper;
        logic [PER_W-1:0]  adur;
    } t_cfg;

    // Quarter-wave sine entry in units of half scale, from a Q30 Taylor series.
    function automatic logic [31:0] quarter_entry(input int k, input int n_bits,
                                                  input int f_bits);
        logic [63:0]        kk;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [65:0] sum;
        logic [65:0]        r;
        kk = 64'(k);
        if (k > (1 << n_bits)) begin
            kk = 64'd1 << n_bits;
        end
        x   = (PI_Q30 * kk) >> (n_bits + 1);
        x2  = (x * x) >> 30;
        t   = x;
        sum = $signed({2'b00, x});
        for (int n = 1; n <= 7; n++) begin
            t = (t * x2) >> 30;
            case (n)
                1: t = t / 64'd6;
                2: t = t / 64'd20;
                3: t = t / 64'd42;
                4: t = t / 64'd72;
                5: t = t / 64'd110;
                6: t = t / 64'd156;
                default: t = t / 64'd210;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - $signed({2'b00, t});
            end else begin
                sum = sum + $signed({2'b00, t});
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        r = ($unsigned(sum) << (f_bits - 1)) + (66'd1 << 29);
        r = r >> 30;
        if (r > (66'd1 << (f_bits - 1))) begin
            r = 66'd1 << (f_bits - 1);
        end
        return r[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/twg_rem.sv =====
// Pipelined restoring remainder unit, one dividend bit per stage.
`default_nettype none
module twg_rem #(
    parameter int DW = 32,
    parameter int VW = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [DW-1:0] i_dvd,
    input  wire logic [VW-1:0] i_dvs,
    output logic               o_vld,
    output logic [VW-1:0]      o_rem
);
    logic [DW-1:0] r_vld;
    logic [VW-1:0] r_rem [DW];
    logic [DW-1:0] r_dvd [DW];
    logic [VW-1:0] n_rem [DW];
    logic [DW-1:0] n_dvd [DW];

    always_comb begin
        logic [VW:0] v_trial;
        v_trial  = {{VW{1'b0}}, i_dvd[DW-1]};
        n_rem[0] = (v_trial >= {1'b0, i_dvs}) ? VW'(v_trial - {1'b0, i_dvs}) : VW'(v_trial);
        n_dvd[0] = i_dvd << 1;
        for (int s = 1; s < DW; s++) begin
            v_trial  = {r_rem[s-1], r_dvd[s-1][DW-1]};
            n_rem[s] = (v_trial >= {1'b0, i_dvs}) ? VW'(v_trial - {1'b0, i_dvs})
                                                  : VW'(v_trial);
            n_dvd[s] = r_dvd[s-1] << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DW-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DW; s++) begin
                r_rem[s] <= n_rem[s];
                r_dvd[s] <= n_dvd[s];
            end
        end
    end

    assign o_vld = r_vld[DW-1];
    assign o_rem = r_rem[DW-1];
endmodule
`default_nettype wire

// ===== rtl/twg_frac.sv =====
// Pipelined fractional divider: quotient bits of num / divisor, one bit per stage.
`default_nettype none
module twg_frac #(
    parameter int VW = 24,
    parameter int QW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [VW-1:0] i_num,
    input  wire logic [VW-1:0] i_dvs,
    input  wire logic          i_tag,
    output logic               o_vld,
    output logic [QW-1:0]      o_quo,
    output logic [VW-1:0]      o_num,
    output logic               o_tag
);
    logic [QW-1:0] r_vld;
    logic [QW-1:0] r_tag;
    logic [VW-1:0] r_rem [QW];
    logic [QW-1:0] r_quo [QW];
    logic [VW-1:0] r_num [QW];
    logic [VW-1:0] n_rem [QW];
    logic [QW-1:0] n_quo [QW];

    always_comb begin
        logic [VW:0] v_trial;
        logic        v_bit;
        v_trial  = {i_num, 1'b0};
        v_bit    = (v_trial >= {1'b0, i_dvs});
        n_rem[0] = v_bit ? VW'(v_trial - {1'b0, i_dvs}) : VW'(v_trial);
        n_quo[0] = {{(QW-1){1'b0}}, v_bit};
        for (int s = 1; s < QW; s++) begin
            v_trial  = {r_rem[s-1], 1'b0};
            v_bit    = (v_trial >= {1'b0, i_dvs});
            n_rem[s] = v_bit ? VW'(v_trial - {1'b0, i_dvs}) : VW'(v_trial);
            n_quo[s] = {r_quo[s-1][QW-2:0], v_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag    <= {r_tag[QW-2:0], i_tag};
            r_num[0] <= i_num;
            for (int s = 0; s < QW; s++) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
            end
            for (int s = 1; s < QW; s++) begin
                r_num[s] <= r_num[s-1];
            end
        end
    end

    assign o_vld = r_vld[QW-1];
    assign o_quo = r_quo[QW-1];
    assign o_num = r_num[QW-1];
    assign o_tag = r_tag[QW-1];
endmodule
`default_nettype wire

// ===== rtl/twg_shape.sv =====
// Waveform shaping, sine table lookup and value scaling in four register stages.
`default_nettype none
module twg_shape #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int AMP_FRAC_BITS   = 16,
    parameter int QUO_W           = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire logic [QUO_W-1:0]              i_quo,
    input  wire logic [twg_pkg::PER_W-1:0]     i_num,
    input  wire logic [twg_pkg::PER_W-1:0]     i_per,
    input  wire logic                          i_tag,
    input  wire twg_pkg::t_cfg                 i_cfg,
    output logic                               o_vld,
    output logic [AMP_FRAC_BITS:0]             o_amp,
    output logic [twg_pkg::VAL_W-1:0]          o_value,
    output logic                               o_flag,
    output logic                               o_present,
    output logic                               o_alert
);
    import twg_pkg::*;

    localparam int N     = SINE_TABLE_BITS;
    localparam int F     = AMP_FRAC_BITS;
    localparam int AMP_W = F + 1;
    localparam int QN    = 1 << N;
    localparam int PW    = VAL_W + AMP_W;
    localparam logic [AMP_W-1:0] C_ONE  = AMP_W'(1) << F;
    localparam logic [AMP_W-1:0] C_HALF = AMP_W'(1) << (F - 1);

    logic [F-1:0] w_qtab [QN+1];

    for (genvar g = 0; g <= QN; g++) begin : g_tab
        assign w_qtab[g] = F'(quarter_entry(g, N, F));
    end

    logic [3:0]       r_vld;
    logic             r_lt;
    logic [VAL_W-1:0] r_mop;
    logic [16:0]      r_nl;

    logic [F-1:0]     r1_f;
    logic [1:0]       r1_q;
    logic [N:0]       r1_tidx;
    logic             r1_sq;
    logic             r1_tag;
    logic [AMP_W-1:0] r2_amp;
    logic             r2_tag;
    logic [PW-1:0]    r3_prod;
    logic [AMP_W-1:0] r3_amp;
    logic             r3_tag;
    logic [AMP_W-1:0] r_amp;
    logic [VAL_W-1:0] r_value;
    logic             r_flag;
    logic             r_present;
    logic             r_alert;

    always_ff @(posedge i_clk) begin
        logic signed [32:0] v_diff;
        logic signed [32:0] v_negl;
        logic signed [32:0] v_negh;
        logic signed [16:0] v_nl;
        logic signed [16:0] v_nh;
        logic signed [17:0] v_dn;
        v_diff = $signed({i_cfg.high[31], i_cfg.high}) - $signed({i_cfg.low[31], i_cfg.low});
        v_negl = -$signed({i_cfg.low[31], i_cfg.low});
        v_negh = -$signed({i_cfg.high[31], i_cfg.high});
        v_nl   = i_cfg.low[31] ? -$signed({1'b0, v_negl[31:16]})
                               : $signed({1'b0, i_cfg.low[31:16]});
        v_nh   = i_cfg.high[31] ? -$signed({1'b0, v_negh[31:16]})
                                : $signed({1'b0, i_cfg.high[31:16]});
        v_dn   = 18'(v_nh) - 18'(v_nl);
        r_lt   <= $signed(i_cfg.low) < $signed(i_cfg.high);
        r_nl   <= v_nl;
        case (i_cfg.kind)
            KIND_INT:  r_mop <= ($signed(i_cfg.low) < $signed(i_cfg.high))
                                ? {16'd0, v_diff[31:16]} : VAL_W'(1);
            KIND_RINT: r_mop <= {14'd0, v_dn};
            default:   r_mop <= v_diff[31:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [N-1:0]      v_k;
        logic [AMP_W-1:0]  v_s;
        logic [AMP_W-1:0]  v_tri;
        logic [VAL_W:0]    v_sh;
        logic [AMP_W+15:0] v_unit;
        logic [VAL_W-1:0]  v_int;
        logic              v_flag;
        if (i_en) begin
            v_k     = i_quo[QUO_W-3 -: N];
            r1_f    <= i_quo[QUO_W-1 -: F];
            r1_q    <= i_quo[QUO_W-1 -: 2];
            r1_tidx <= i_quo[QUO_W-2] ? (N+1)'(QN) - {1'b0, v_k} : {1'b0, v_k};
            r1_sq   <= (i_num != '0) && ({i_num, 1'b0} < {1'b0, i_per});
            r1_tag  <= i_tag;

            v_s   = {1'b0, w_qtab[r1_tidx]};
            v_tri = {r1_f, 1'b0};
            case (i_cfg.waveform)
                WAVE_SAW:     r2_amp <= {1'b0, r1_f};
                WAVE_INV_SAW: r2_amp <= C_ONE - {1'b0, r1_f};
                WAVE_SINE:    r2_amp <= r1_q[1] ? C_HALF - v_s : C_HALF + v_s;
                WAVE_SQUARE:  r2_amp <= r1_sq ? C_ONE : '0;
                WAVE_TRI:     r2_amp <= (v_tri > C_ONE) ? AMP_W'(0) - v_tri : v_tri;
                default:      r2_amp <= '0;
            endcase
            r2_tag <= r1_tag;

            r3_prod <= PW'(r_mop) * PW'(r2_amp);
            r3_amp  <= r2_amp;
            r3_tag  <= r2_tag;

            v_sh   = r3_prod[F +: VAL_W+1];
            v_unit = {r3_amp, 16'd0} >> F;
            v_flag = r3_amp > C_HALF;
            v_int  = VAL_W'($signed(r_nl)) + v_sh[VAL_W-1:0];
            r_amp   <= r3_amp;
            r_alert <= r3_tag;
            r_flag  <= (i_cfg.kind == KIND_BOOL) && v_flag;
            case (i_cfg.kind)
                KIND_BOOL: begin
                    r_value   <= v_flag ? 32'h0001_0000 : '0;
                    r_present <= 1'b1;
                end
                KIND_RANGE: begin
                    r_value   <= r_lt ? i_cfg.low + v_sh[VAL_W-1:0] : 32'(v_unit);
                    r_present <= 1'b1;
                end
                KIND_INT: begin
                    r_value   <= (v_sh > 33'd32767) ? {16'd32767, 16'd0}
                                                    : {v_sh[15:0], 16'd0};
                    r_present <= 1'b1;
                end
                KIND_RINT: begin
                    r_value   <= r_lt ? {v_int[15:0], 16'd0} : '0;
                    r_present <= r_lt;
                end
                default: begin
                    r_value   <= '0;
                    r_present <= 1'b0;
                end
            endcase
        end
    end

    assign o_vld     = r_vld[3];
    assign o_amp     = r_amp;
    assign o_value   = r_value;
    assign o_flag    = r_flag;
    assign o_present = r_present;
    assign o_alert   = r_alert;
endmodule
`default_nettype wire

// ===== rtl/test_waveform_generator_unit.sv =====
// Throughput: one transaction per cycle; the whole pipeline advances when the output
// register is empty or taken, so a stall holds every stage.
// Latency is set by the bit-serial remainder stages, the fractional divider stages and the shaping stages.
// Reset is synchronous and active low: valid bits clear and configuration registers take defaults.
`default_nettype none
module test_waveform_generator_unit #(
    parameter int SINE_TABLE_BITS = twg_pkg::SINE_TABLE_BITS_DEF,
    parameter int AMP_FRAC_BITS   = twg_pkg::AMP_FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [twg_pkg::TIME_W-1:0]    i_s_axis_tdata,  // time_ms
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // amplitude, value_out, flag_out, value_present, alert_on, zero fill
    output logic [((AMP_FRAC_BITS+36+7)/8)*8-1:0] o_m_axis_tdata,
    input  wire logic                          i_cfg_we,
    input  wire logic [twg_pkg::ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [twg_pkg::VAL_W-1:0]     i_cfg_data
);
    import twg_pkg::*;

    localparam int AMP_W = AMP_FRAC_BITS + 1;
    localparam int ODW   = ((AMP_FRAC_BITS + 36 + 7) / 8) * 8;
    localparam int QW    = (AMP_FRAC_BITS > SINE_TABLE_BITS + 2) ? AMP_FRAC_BITS
                                                                 : SINE_TABLE_BITS + 2;
    localparam logic [AMP_W-1:0] C_ONE = AMP_W'(1) << AMP_FRAC_BITS;

    t_cfg r_cfg;
    logic w_en;
    logic [PER_W-1:0] w_per;
    logic [PER_W-1:0] w_aper;
    logic w_rvld;
    logic w_avld;
    logic [PER_W-1:0] w_rem;
    logic [PER_W-1:0] w_arem;
    logic w_fvld;
    logic [QW-1:0] w_quo;
    logic [PER_W-1:0] w_num;
    logic w_ftag;
    logic w_ovld;
    logic [AMP_W-1:0] w_amp;
    logic [VAL_W-1:0] w_value;
    logic w_flag;
    logic w_present;
    logic w_alert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period   <= PER_W'(10000);
            r_cfg.waveform <= WAVE_SINE;
            r_cfg.kind     <= KIND_RANGE;
            r_cfg.low      <= '0;
            r_cfg.high     <= '0;
            r_cfg.aper     <= PER_W'(200000);
            r_cfg.adur     <= PER_W'(20000);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_PERIOD:     r_cfg.period   <= i_cfg_data[PER_W-1:0];
                REG_WAVEFORM:   r_cfg.waveform <= i_cfg_data[CODE_W-1:0];
                REG_VALUE_KIND: r_cfg.kind     <= i_cfg_data[CODE_W-1:0];
                REG_LOW:        r_cfg.low      <= i_cfg_data;
                REG_HIGH:       r_cfg.high     <= i_cfg_data;
                REG_ALERT_PER:  r_cfg.aper     <= i_cfg_data[PER_W-1:0];
                REG_ALERT_DUR:  r_cfg.adur     <= i_cfg_data[PER_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_per  = (r_cfg.period == '0) ? PER_W'(1) : r_cfg.period;
    assign w_aper = (r_cfg.aper == '0) ? PER_W'(1) : r_cfg.aper;
    assign w_en   = !w_ovld || i_m_axis_tready;

    twg_rem #(.DW(TIME_W), .VW(PER_W)) u_rem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(i_s_axis_tvalid),
        .i_dvd(i_s_axis_tdata), .i_dvs(w_per), .o_vld(w_rvld), .o_rem(w_rem)
    );

    twg_rem #(.DW(TIME_W), .VW(PER_W)) u_arem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(i_s_axis_tvalid),
        .i_dvd(i_s_axis_tdata), .i_dvs(w_aper), .o_vld(w_avld), .o_rem(w_arem)
    );

    twg_frac #(.VW(PER_W), .QW(QW)) u_frac (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(w_rvld && w_avld),
        .i_num(w_rem), .i_dvs(w_per), .i_tag(w_arem < r_cfg.adur),
        .o_vld(w_fvld), .o_quo(w_quo), .o_num(w_num), .o_tag(w_ftag)
    );

    twg_shape #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS), .AMP_FRAC_BITS(AMP_FRAC_BITS), .QUO_W(QW)
    ) u_shape (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(w_fvld),
        .i_quo(w_quo), .i_num(w_num), .i_per(w_per), .i_tag(w_ftag), .i_cfg(r_cfg),
        .o_vld(w_ovld), .o_amp(w_amp), .o_value(w_value), .o_flag(w_flag),
        .o_present(w_present), .o_alert(w_alert)
    );

    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = w_ovld;
    assign o_m_axis_tdata  = {{(ODW-AMP_W-35){1'b0}}, w_alert, w_present, w_flag,
                              w_value, w_amp};

    a_amp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ovld |-> w_amp <= C_ONE)
        else $error("amplitude above full scale");
    a_flag_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ovld && w_flag) |-> (w_value == 32'h0001_0000 && w_present))
        else $error("flag set without unit value");
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ovld && !w_present) |-> (w_value == '0 && !w_flag))
        else $error("absent value not zero");
endmodule
`default_nettype wire
